// ===== hw/rtl/bps_pkg.sv =====
// ----------------------------------------------------------------------------
// bps_pkg
// Shared constants, operation codes and types of the priority scheduler.
// ----------------------------------------------------------------------------
package bps_pkg;

   localparam int NUM_THREADS  = 32;
   localparam int MAX_THREADS  = 32;
   localparam int THREAD_COUNT = (NUM_THREADS < MAX_THREADS) ? NUM_THREADS : MAX_THREADS;
   localparam int TID_W        = 5;
   localparam int CNT_W        = 32;
   localparam int OP_W         = 2;

   localparam logic [TID_W-1:0] LAST_TID = TID_W'(THREAD_COUNT - 1);

   localparam logic [MAX_THREADS-1:0] VALID_MASK =
      (THREAD_COUNT >= MAX_THREADS) ? {MAX_THREADS{1'b1}}
                                    : MAX_THREADS'((64'd1 << THREAD_COUNT) - 64'd1);

   localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
   localparam logic [OP_W-1:0] OP_DELAY = 2'd1;
   localparam logic [OP_W-1:0] OP_YIELD = 2'd2;

   typedef struct packed {
      logic             found;
      logic [TID_W-1:0] tid;
   } pick_type;

endpackage

// ===== hw/rtl/bps_ram.sv =====
// ----------------------------------------------------------------------------
// bps_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bps_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/bps_picker.sv =====
// ----------------------------------------------------------------------------
// bps_picker
// Priority encoder: lowest-numbered ready thread among the threads in use.
// ----------------------------------------------------------------------------
module bps_picker (
   input  logic [bps_pkg::MAX_THREADS-1:0] ready_map,
   output bps_pkg::pick_type               pick
);

   logic [bps_pkg::MAX_THREADS-1:0] map;

   always_comb begin
      map        = ready_map & bps_pkg::VALID_MASK;
      pick.found = |map;
      pick.tid   = '0;
      // scan downward so the lowest set bit wins
      for (int i = bps_pkg::MAX_THREADS - 1; i >= 0; i--) begin
         if (map[i]) begin
            pick.tid = bps_pkg::TID_W'(i);
         end
      end
   end

endmodule

// ===== hw/rtl/bitmap_priority_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// bitmap_priority_scheduler_top
// Tick-driven priority scheduler with per-thread sleep counters in memory.
// ----------------------------------------------------------------------------
// The sleep counters live in a 32-entry RAM with one read and one write port;
// the ready map and running thread are flip-flops. A tick sweeps the counters
// through the RAM, one read and one write-back per cycle, so the length of a
// tick is set by the single RAM read port. Counter entries carry reset-cleared
// valid bits, so the block is usable right after reset with no clearing pass.
// A finished result sits in an output register, and the next request is taken
// while it waits.
// ----------------------------------------------------------------------------
module bitmap_priority_scheduler_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [bps_pkg::OP_W-1:0]    req_op,
   input  logic [bps_pkg::CNT_W-1:0]   req_delay_ticks,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [bps_pkg::TID_W-1:0]   rsp_running_thread,
   output logic [bps_pkg::TID_W-1:0]   rsp_previous_thread,
   output logic                        rsp_switch_request
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SWEEP = 2'd1;
   localparam logic [1:0] S_PICK  = 2'd2;

   logic [1:0]                        state_ff, state_in;
   logic [bps_pkg::MAX_THREADS-1:0]   ready_ff, ready_in;
   logic [bps_pkg::MAX_THREADS-1:0]   ent_vld_ff, ent_vld_in;
   logic [bps_pkg::TID_W-1:0]         cur_ff, cur_in;
   logic                              choose_ff, choose_in;
   logic [bps_pkg::TID_W-1:0]         cnt_ff, cnt_in;
   logic                              rd_pend_ff, rd_pend_in;
   logic [bps_pkg::TID_W-1:0]         rd_idx_ff, rd_idx_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [bps_pkg::TID_W-1:0]         rsp_run_ff, rsp_run_in;
   logic [bps_pkg::TID_W-1:0]         rsp_prev_ff, rsp_prev_in;
   logic                              rsp_sw_ff, rsp_sw_in;

   logic                              wr_en;
   logic [bps_pkg::TID_W-1:0]         wr_addr;
   logic [bps_pkg::CNT_W-1:0]         wr_data;
   logic                              rd_en;
   logic [bps_pkg::CNT_W-1:0]         rd_data;
   logic [bps_pkg::CNT_W-1:0]         cnt_val;
   bps_pkg::pick_type                 pick;
   logic [bps_pkg::TID_W-1:0]         next_tid;
   logic                              req_xfer;
   logic                              out_free;

   bps_ram #(
      .WIDTH(bps_pkg::CNT_W),
      .DEPTH(bps_pkg::MAX_THREADS)
   ) u_sleep_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(cnt_ff),
      .rd_data(rd_data)
   );

   bps_picker u_picker (
      .ready_map(ready_ff),
      .pick     (pick)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   // entries never written read as zero
   assign cnt_val   = ent_vld_ff[rd_idx_ff] ? rd_data : '0;
   assign next_tid  = (choose_ff && pick.found) ? pick.tid : cur_ff;

   always_comb begin
      state_in     = state_ff;
      ready_in     = ready_ff;
      ent_vld_in   = ent_vld_ff;
      cur_in       = cur_ff;
      choose_in    = choose_ff;
      cnt_in       = cnt_ff;
      rd_pend_in   = 1'b0;
      rd_idx_in    = rd_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_run_in   = rsp_run_ff;
      rsp_prev_in  = rsp_prev_ff;
      rsp_sw_in    = rsp_sw_ff;
      wr_en        = 1'b0;
      wr_addr      = cur_ff;
      wr_data      = req_delay_ticks;
      rd_en        = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               unique case (req_op)
                  bps_pkg::OP_TICK: begin
                     cnt_in    = '0;
                     choose_in = 1'b1;
                     state_in  = S_SWEEP;
                  end
                  bps_pkg::OP_DELAY: begin
                     choose_in = (req_delay_ticks != '0);
                     state_in  = S_PICK;
                     if (req_delay_ticks != '0) begin
                        wr_en              = 1'b1;
                        ent_vld_in[cur_ff] = 1'b1;
                        ready_in[cur_ff]   = 1'b0;
                     end
                  end
                  bps_pkg::OP_YIELD: begin
                     choose_in = 1'b1;
                     state_in  = S_PICK;
                  end
                  default: begin
                     choose_in = 1'b0;
                     state_in  = S_PICK;
                  end
               endcase
            end
         end
         S_SWEEP: begin
            // issue read of the next counter, skip the idle thread
            if (cnt_ff != bps_pkg::LAST_TID) begin
               rd_en      = 1'b1;
               rd_pend_in = 1'b1;
               rd_idx_in  = cnt_ff;
               cnt_in     = bps_pkg::TID_W'(cnt_ff + 1'b1);
            end else begin
               state_in = S_PICK;
            end
            // write back the counter read last cycle
            if (rd_pend_ff && (cnt_val != '0)) begin
               wr_en                 = 1'b1;
               wr_addr               = rd_idx_ff;
               wr_data               = cnt_val - 1'b1;
               ent_vld_in[rd_idx_ff] = 1'b1;
               if (cnt_val == bps_pkg::CNT_W'(1)) begin
                  ready_in[rd_idx_ff] = 1'b1;
               end
            end
         end
         S_PICK: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_run_in   = next_tid;
               rsp_prev_in  = cur_ff;
               rsp_sw_in    = (next_tid != cur_ff);
               cur_in       = next_tid;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ready_ff     <= bps_pkg::VALID_MASK;
         ent_vld_ff   <= '0;
         cur_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ready_ff     <= ready_in;
         ent_vld_ff   <= ent_vld_in;
         cur_ff       <= cur_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      choose_ff   <= choose_in;
      cnt_ff      <= cnt_in;
      rd_idx_ff   <= rd_idx_in;
      rsp_run_ff  <= rsp_run_in;
      rsp_prev_ff <= rsp_prev_in;
      rsp_sw_ff   <= rsp_sw_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_running_thread  = rsp_run_ff;
   assign rsp_previous_thread = rsp_prev_ff;
   assign rsp_switch_request  = rsp_sw_ff;

endmodule

// ===== dv/bitmap_priority_scheduler_top_tb.sv =====
// ----------------------------------------------------------------------------
// bitmap_priority_scheduler_top_tb
// Self-checking bench for the tick-driven priority scheduler.
// ----------------------------------------------------------------------------
// A queue of scheduler commands (tick, delay, yield, unused code) is built up
// front: a directed opener, then random traffic mixed with bursts that put
// every thread to sleep, the idle thread included. A clocked driver offers the
// commands with random gaps; a clocked receiver takes results with random
// waits and one long hold-off. Each accepted command is run through a local
// model of the counters, ready bits and running thread, and every result is
// compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module bitmap_priority_scheduler_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [bps_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int DIRECTED_N     = 20;
   localparam int RANDOM_N       = 600;
   localparam int TICK_CYCLES    = bps_pkg::THREAD_COUNT + 2;
   localparam int HOLD_AT        = 150;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef struct {
      logic [bps_pkg::OP_W-1:0]  op;
      logic [bps_pkg::CNT_W-1:0] ticks;
   } sched_cmd_type;

   typedef struct {
      logic [bps_pkg::TID_W-1:0] running;
      logic [bps_pkg::TID_W-1:0] previous;
      logic                      switched;
   } sched_pick_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [bps_pkg::OP_W-1:0]     req_op = '0;
   logic [bps_pkg::CNT_W-1:0]    req_delay_ticks = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [bps_pkg::TID_W-1:0]    rsp_running_thread;
   logic [bps_pkg::TID_W-1:0]    rsp_previous_thread;
   logic                         rsp_switch_request;

   sched_cmd_type  cmd_queue[$];
   sched_pick_type expected_picks[$];

   // model state of the scheduler
   logic [bps_pkg::CNT_W-1:0]       sleep_cnt [bps_pkg::MAX_THREADS];
   logic [bps_pkg::MAX_THREADS-1:0] ready_bits;
   logic [bps_pkg::TID_W-1:0]       cur_tid;

   int fail_n = 0;
   int tick_n = 0;
   int delay_n = 0;
   int none_ready_n = 0;
   int switch_n = 0;
   int sent_n = 0;
   int recv_n = 0;
   int gap_left = 0;
   int rsp_wait = 0;
   int rsp_seen = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   int idle_cycles = 0;

   bitmap_priority_scheduler_top u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_op              (req_op),
      .req_delay_ticks     (req_delay_ticks),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_running_thread  (rsp_running_thread),
      .rsp_previous_thread (rsp_previous_thread),
      .rsp_switch_request  (rsp_switch_request)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Every fourth stretch of 50 transfers runs with no idling.
   function automatic int draw_wait(input int n);
      if ((n / 50) % 4 == 3)
         return 0;
      return $urandom_range(0, 10);
   endfunction

   function automatic void add_cmd(input logic [bps_pkg::OP_W-1:0] op,
                                   input logic [bps_pkg::CNT_W-1:0] ticks);
      sched_cmd_type c;
      c.op = op;
      c.ticks = ticks;
      cmd_queue.push_back(c);
   endfunction

   // Apply one command to the model and return the thread choice it causes.
   function automatic sched_pick_type schedule_next_thread(
      input logic [bps_pkg::OP_W-1:0]  op,
      input logic [bps_pkg::CNT_W-1:0] ticks);
      sched_pick_type                  pick;
      logic                            choose;
      logic [bps_pkg::MAX_THREADS-1:0] live;
      int                              t;
      pick.previous = cur_tid;
      choose = 1'b0;
      case (op)
         bps_pkg::OP_TICK: begin
            tick_n++;
            for (t = 0; t < bps_pkg::THREAD_COUNT - 1; t++) begin
               if (sleep_cnt[t] != '0) begin
                  sleep_cnt[t] = sleep_cnt[t] - 1'b1;
                  if (sleep_cnt[t] == '0)
                     ready_bits[t] = 1'b1;
               end
            end
            choose = 1'b1;
         end
         bps_pkg::OP_DELAY: begin
            delay_n++;
            if (ticks != '0) begin
               sleep_cnt[cur_tid] = ticks;
               ready_bits[cur_tid] = 1'b0;
               choose = 1'b1;
            end
         end
         bps_pkg::OP_YIELD: choose = 1'b1;
         default: ;
      endcase
      ready_bits = ready_bits & bps_pkg::VALID_MASK;
      if (choose) begin
         live = ready_bits & bps_pkg::VALID_MASK;
         if (live == '0) begin
            none_ready_n++;
         end else begin
            // scan downward so the lowest ready thread is the last one taken
            for (t = bps_pkg::MAX_THREADS - 1; t >= 0; t--)
               if (live[t])
                  cur_tid = bps_pkg::TID_W'(t);
         end
      end
      pick.running = cur_tid;
      pick.switched = (cur_tid != pick.previous);
      return pick;
   endfunction

   // Driver: offer commands, hold until transfer, then idle for the drawn gap.
   always @(posedge clock) begin
      sched_cmd_type c;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left <= 0;
      end else if (req_valid && !req_ready) begin
         // hold payload until transfer
      end else if (gap_left != 0) begin
         req_valid <= 1'b0;
         gap_left <= gap_left - 1;
      end else if (cmd_queue.size() != 0) begin
         c = cmd_queue.pop_front();
         req_valid <= 1'b1;
         req_op <= c.op;
         req_delay_ticks <= c.ticks;
         gap_left <= draw_wait(sent_n);
         sent_n <= sent_n + 1;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Receiver: after each transfer wait a drawn number of cycles before ready.
   always @(posedge clock) begin
      int w;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait <= 0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         w = draw_wait(recv_n);
         recv_n <= recv_n + 1;
         rsp_wait <= w;
         rsp_ready <= (w == 0);
      end else if (rsp_wait != 0) begin
         rsp_wait <= rsp_wait - 1;
         rsp_ready <= (rsp_wait == 1);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Long hold-off on the result side so the block backs up into its input.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         rsp_seen <= rsp_seen + 1;
      if (!hold_done && rsp_seen == HOLD_AT) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Monitor: check results against predictions, predict each accepted command.
   always @(posedge clock) begin
      sched_pick_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_picks.size() == 0) begin
               $error("result with nothing pending: running_thread %0d", rsp_running_thread);
               fail_n++;
            end else begin
               want = expected_picks.pop_front();
               if (rsp_running_thread !== want.running) begin
                  $error("running_thread: expected %0d, actual %0d",
                         want.running, rsp_running_thread);
                  fail_n++;
               end
               if (rsp_previous_thread !== want.previous) begin
                  $error("previous_thread: expected %0d, actual %0d",
                         want.previous, rsp_previous_thread);
                  fail_n++;
               end
               if (rsp_switch_request !== want.switched) begin
                  $error("switch_request: expected %0d, actual %0d",
                         want.switched, rsp_switch_request);
                  fail_n++;
               end
               if (rsp_switch_request === 1'b1)
                  switch_n++;
            end
         end
         if (req_valid && req_ready)
            expected_picks.push_back(schedule_next_thread(req_op, req_delay_ticks));
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $error("no transfer for %0d cycles", WATCHDOG_LIMIT);
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int r;
      int k;
      int i;
      for (i = 0; i < bps_pkg::MAX_THREADS; i++)
         sleep_cnt[i] = '0;
      ready_bits = bps_pkg::VALID_MASK;
      cur_tid = '0;

      // directed opener
      add_cmd(bps_pkg::OP_YIELD, $urandom());
      add_cmd(OP_UNUSED, $urandom());
      add_cmd(bps_pkg::OP_DELAY, '0);
      add_cmd(bps_pkg::OP_TICK, '0);
      add_cmd(bps_pkg::OP_DELAY, 32'd1);
      add_cmd(bps_pkg::OP_DELAY, 32'd2);
      add_cmd(bps_pkg::OP_TICK, 32'hAAAA_AAAA);
      add_cmd(bps_pkg::OP_TICK, 32'h5555_5555);
      add_cmd(bps_pkg::OP_DELAY, 32'hFFFF_FFFF);
      add_cmd(bps_pkg::OP_YIELD, 32'hFFFF_FFFF);
      add_cmd(OP_UNUSED, '0);
      add_cmd(OP_UNUSED, 32'hFFFF_FFFF);
      add_cmd(bps_pkg::OP_DELAY, 32'd3);
      add_cmd(bps_pkg::OP_TICK, $urandom());
      add_cmd(bps_pkg::OP_TICK, $urandom());
      add_cmd(bps_pkg::OP_TICK, $urandom());
      add_cmd(bps_pkg::OP_YIELD, '0);
      add_cmd(bps_pkg::OP_DELAY, '0);
      add_cmd(bps_pkg::OP_DELAY, 32'd1);
      add_cmd(bps_pkg::OP_TICK, 32'h0000_0001);

      // random traffic with bursts that sleep every thread, idle one too
      while (cmd_queue.size() < DIRECTED_N + RANDOM_N) begin
         r = $urandom_range(0, 99);
         if (r < 2) begin
            for (i = 0; i < bps_pkg::MAX_THREADS + 2; i++)
               add_cmd(bps_pkg::OP_DELAY, $urandom_range(1, 4));
            for (i = 0; i < 6; i++)
               add_cmd(bps_pkg::OP_TICK, $urandom());
         end else begin
            k = $urandom_range(0, 99);
            if (k < 40)
               add_cmd(bps_pkg::OP_TICK, $urandom());
            else if (k < 75)
               add_cmd(bps_pkg::OP_DELAY, $urandom_range(1, 6));
            else if (k < 76)
               add_cmd(bps_pkg::OP_DELAY, $urandom());
            else if (k < 90)
               add_cmd(bps_pkg::OP_YIELD, $urandom());
            else if (k < 95)
               add_cmd(OP_UNUSED, $urandom());
            else
               add_cmd(bps_pkg::OP_DELAY, '0);
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (cmd_queue.size() != 0 || req_valid || expected_picks.size() != 0);
      repeat (2 * TICK_CYCLES) @(negedge clock);

      if (expected_picks.size() != 0) begin
         $error("%0d results never arrived", expected_picks.size());
         fail_n++;
      end
      $display("run covered %0d commands: %0d ticks, %0d delays, %0d context switches",
               sent_n, tick_n, delay_n, switch_n);
      $display("picks with no ready thread: %0d, mismatches: %0d", none_ready_n, fail_n);
      if (fail_n == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/bps_pkg.sv
hw/rtl/bps_ram.sv
hw/rtl/bps_picker.sv
hw/rtl/bitmap_priority_scheduler_top.sv
dv/bitmap_priority_scheduler_top_tb.sv
